// ===== rtl/stvk_pkg.sv =====
// Shared types, constants and fixed-point helpers for the triangle force block.
// Used by every module under rtl/; depends on nothing else.
package stvk_pkg;

    // Word width of all coordinates, forces and coefficients.
    localparam int W = 32;
    // Default fractional bits of the Q format.
    localparam int FRAC_BITS = 16;
    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 1'd1;
    // Both coefficients reset to 1.0 in the default Q16.16 format.
    localparam logic [W-1:0] LAME_RESET = 32'd65536;

    typedef logic signed [W-1:0] q_t;
    typedef logic signed [2*W-1:0] prod_t;

    localparam q_t Q_MAX = 32'sh7fffffff;
    localparam q_t Q_MIN = 32'sh80000000;

    // One input request: rest and current positions of the three vertices.
    typedef struct packed {
        q_t rest_ax;
        q_t rest_ay;
        q_t rest_bx;
        q_t rest_by;
        q_t rest_cx;
        q_t rest_cy;
        q_t cur_ax;
        q_t cur_ay;
        q_t cur_bx;
        q_t cur_by;
        q_t cur_cx;
        q_t cur_cy;
    } tri_in_t;

    // One result: nodal forces and status flags.
    typedef struct packed {
        q_t   force_ax;
        q_t   force_ay;
        q_t   force_bx;
        q_t   force_by;
        q_t   force_cx;
        q_t   force_cy;
        logic degenerate;
        logic saturated;
    } tri_out_t;

    // Rest edges and determinant status that travel down the pipe.
    typedef struct packed {
        q_t   e1x;
        q_t   e1y;
        q_t   e2x;
        q_t   e2y;
        logic det_pos;
        logic degen;
    } edge_side_t;

    // Output of the geometry stages: det(B) and N = D * adj(B).
    typedef struct packed {
        q_t         det;
        q_t [3:0]   n;
        edge_side_t side;
    } geom_t;

    // Deformation gradient, order f00, f01, f10, f11.
    typedef struct packed {
        q_t [3:0]   f;
        edge_side_t side;
    } grad_t;

    // Gradient plus the stress factor M.
    typedef struct packed {
        q_t [3:0]   f;
        q_t         m00;
        q_t         m01;
        q_t         m11;
        edge_side_t side;
    } stress_t;

    // Material coefficients from the configuration registers.
    typedef struct packed {
        logic [W-1:0] alpha;
        logic [W-1:0] beta;
    } lame_t;

    // Clamp a wide signed value to the 32-bit range.
    function automatic q_t sat32(input prod_t x);
        q_t r;
        if (x > 64'sd2147483647)
            r = Q_MAX;
        else if (x < -64'sd2147483648)
            r = Q_MIN;
        else
            r = x[W-1:0];
        return r;
    endfunction

    // Sum of two halved products (floor), each optionally negated, plus a bias.
    function automatic prod_t half_sum(input prod_t a, input prod_t b,
                                       input logic neg_a, input logic neg_b,
                                       input prod_t bias);
        prod_t ta;
        prod_t tb;
        ta = neg_a ? -a : a;
        tb = neg_b ? -b : b;
        return (ta >>> 1) + (tb >>> 1) + bias;
    endfunction

    // Arithmetic right shift with round half up.
    function automatic prod_t rnd_shift(input prod_t x, input int unsigned s);
        prod_t h;
        h = 64'sd1 <<< (s - 1);
        return (x + h) >>> s;
    endfunction

endpackage

// ===== rtl/stvk_geom.sv =====
// Geometry front end: edge differences, edge products, det(B) and N = D * adj(B).
// Three register stages; depends on stvk_pkg.
module stvk_geom #(
    parameter int FRAC_BITS = stvk_pkg::FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  stvk_pkg::tri_in_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output stvk_pkg::geom_t   out_data
);

    localparam int NS = 3;

    logic [NS-1:0]   vld_reg;
    logic [NS-1:0]   adv;
    stvk_pkg::q_t    edge_reg [0:7];
    stvk_pkg::prod_t prod_reg [0:9];
    stvk_pkg::q_t    ecopy_reg [0:3];
    stvk_pkg::geom_t out_reg;
    stvk_pkg::geom_t out_next;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int s = NS - 2; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NS-1];
    assign out_data  = out_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (adv[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // Final stage: round the product pairs to det and N.
    always_comb
    begin
        out_next.det = stvk_pkg::sat32(stvk_pkg::rnd_shift(
            stvk_pkg::half_sum(prod_reg[0], prod_reg[1], 1'b0, 1'b1, '0), FRAC_BITS - 1));
        out_next.n[0] = stvk_pkg::sat32(stvk_pkg::rnd_shift(
            stvk_pkg::half_sum(prod_reg[2], prod_reg[3], 1'b0, 1'b1, '0), FRAC_BITS - 1));
        out_next.n[1] = stvk_pkg::sat32(stvk_pkg::rnd_shift(
            stvk_pkg::half_sum(prod_reg[4], prod_reg[5], 1'b1, 1'b0, '0), FRAC_BITS - 1));
        out_next.n[2] = stvk_pkg::sat32(stvk_pkg::rnd_shift(
            stvk_pkg::half_sum(prod_reg[6], prod_reg[7], 1'b0, 1'b1, '0), FRAC_BITS - 1));
        out_next.n[3] = stvk_pkg::sat32(stvk_pkg::rnd_shift(
            stvk_pkg::half_sum(prod_reg[8], prod_reg[9], 1'b1, 1'b0, '0), FRAC_BITS - 1));
        out_next.side.e1x     = ecopy_reg[0];
        out_next.side.e1y     = ecopy_reg[1];
        out_next.side.e2x     = ecopy_reg[2];
        out_next.side.e2y     = ecopy_reg[3];
        out_next.side.degen   = (out_next.det == '0);
        out_next.side.det_pos = !out_next.det[stvk_pkg::W-1] && (out_next.det != '0);
    end

    // Payload registers of the three stages.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            edge_reg[0] <= stvk_pkg::sat32(64'(in_data.rest_bx) - 64'(in_data.rest_ax));
            edge_reg[1] <= stvk_pkg::sat32(64'(in_data.rest_by) - 64'(in_data.rest_ay));
            edge_reg[2] <= stvk_pkg::sat32(64'(in_data.rest_cx) - 64'(in_data.rest_ax));
            edge_reg[3] <= stvk_pkg::sat32(64'(in_data.rest_cy) - 64'(in_data.rest_ay));
            edge_reg[4] <= stvk_pkg::sat32(64'(in_data.cur_bx) - 64'(in_data.cur_ax));
            edge_reg[5] <= stvk_pkg::sat32(64'(in_data.cur_by) - 64'(in_data.cur_ay));
            edge_reg[6] <= stvk_pkg::sat32(64'(in_data.cur_cx) - 64'(in_data.cur_ax));
            edge_reg[7] <= stvk_pkg::sat32(64'(in_data.cur_cy) - 64'(in_data.cur_ay));
        end
        if (adv[1])
        begin
            // Order: e1,e2 as rest edges; d1,d2 as current edges.
            prod_reg[0] <= edge_reg[0] * edge_reg[3];
            prod_reg[1] <= edge_reg[2] * edge_reg[1];
            prod_reg[2] <= edge_reg[4] * edge_reg[3];
            prod_reg[3] <= edge_reg[6] * edge_reg[1];
            prod_reg[4] <= edge_reg[4] * edge_reg[2];
            prod_reg[5] <= edge_reg[6] * edge_reg[0];
            prod_reg[6] <= edge_reg[5] * edge_reg[3];
            prod_reg[7] <= edge_reg[7] * edge_reg[1];
            prod_reg[8] <= edge_reg[5] * edge_reg[2];
            prod_reg[9] <= edge_reg[7] * edge_reg[0];
            for (int i = 0; i < 4; i++)
            begin
                ecopy_reg[i] <= edge_reg[i];
            end
        end
        if (adv[2])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/stvk_div.sv =====
// Pipelined restoring divider: F = N * 2^FRAC_BITS / det, truncated and saturated.
// One quotient bit per stage for four lanes sharing det; depends on stvk_pkg.
module stvk_div #(
    parameter int FRAC_BITS = stvk_pkg::FRAC_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  stvk_pkg::geom_t in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output stvk_pkg::grad_t out_data
);

    localparam int W   = stvk_pkg::W;
    localparam int NB  = W - 1;
    localparam int DVW = W + FRAC_BITS;
    localparam int CW  = 2 * W - 1;
    localparam int NS  = NB + 2;

    logic [NS-1:0]        vld_reg;
    logic [NS-1:0]        adv;
    logic [DVW-1:0]       rem_reg  [0:NB][0:3];
    logic [DVW-1:0]       rem_next [0:NB][0:3];
    logic [NB-1:0]        q_reg    [0:NB][0:3];
    logic [NB-1:0]        q_next   [0:NB][0:3];
    logic [3:0]           ovf_reg  [0:NB];
    logic [3:0]           ovf_next [0:NB];
    logic [3:0]           neg_reg  [0:NB];
    logic [3:0]           neg_next [0:NB];
    logic [W-1:0]         dabs_reg [0:NB];
    logic [W-1:0]         dabs_next[0:NB];
    stvk_pkg::edge_side_t side_reg [0:NB];
    stvk_pkg::edge_side_t side_next[0:NB];
    stvk_pkg::grad_t      out_reg;
    stvk_pkg::grad_t      out_next;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int s = NS - 2; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NS-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (adv[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // Setup stage: magnitudes, sign of the quotient, and the overflow test
    // (quotient of 2^31 or more saturates). Then the quotient bit stages,
    // most significant bit first.
    always_comb
    begin
        logic [W-1:0]   dabs;
        logic [W-1:0]   nabs;
        logic [DVW-1:0] dvd;
        stvk_pkg::q_t   nv;
        stvk_pkg::q_t   dv;
        logic [CW-1:0]  sh;
        logic           ge;
        int             b;
        dv   = in_data.det;
        dabs = dv[W-1] ? (~dv + 1'b1) : dv;
        dabs_next[0] = dabs;
        side_next[0] = in_data.side;
        for (int i = 0; i < 4; i++)
        begin
            nv   = in_data.n[i];
            nabs = nv[W-1] ? (~nv + 1'b1) : nv;
            dvd  = {nabs, {FRAC_BITS{1'b0}}};
            rem_next[0][i] = dvd;
            q_next[0][i]   = '0;
            ovf_next[0][i] = CW'(dvd) >= (CW'(dabs) << NB);
            neg_next[0][i] = nv[W-1] ^ dv[W-1];
        end
        for (int k = 1; k <= NB; k++)
        begin
            b = NB - k;
            sh = CW'(dabs_reg[k-1]) << b;
            for (int i = 0; i < 4; i++)
            begin
                ge = CW'(rem_reg[k-1][i]) >= sh;
                rem_next[k][i] = ge ? DVW'(CW'(rem_reg[k-1][i]) - sh) : rem_reg[k-1][i];
                q_next[k][i]   = q_reg[k-1][i];
                q_next[k][i][b] = ge;
            end
            ovf_next[k]  = ovf_reg[k-1];
            neg_next[k]  = neg_reg[k-1];
            dabs_next[k] = dabs_reg[k-1];
            side_next[k] = side_reg[k-1];
        end
    end

    // Sign fix and saturation.
    always_comb
    begin
        logic [W-1:0] qv;
        for (int i = 0; i < 4; i++)
        begin
            qv = {1'b0, q_reg[NB][i]};
            if (ovf_reg[NB][i])
                out_next.f[i] = neg_reg[NB][i] ? stvk_pkg::Q_MIN : stvk_pkg::Q_MAX;
            else
                out_next.f[i] = neg_reg[NB][i] ? -qv : qv;
        end
        out_next.side = side_reg[NB];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= NB; k++)
        begin
            if (adv[k])
            begin
                for (int i = 0; i < 4; i++)
                begin
                    rem_reg[k][i] <= rem_next[k][i];
                    q_reg[k][i]   <= q_next[k][i];
                end
                ovf_reg[k]  <= ovf_next[k];
                neg_reg[k]  <= neg_next[k];
                dabs_reg[k] <= dabs_next[k];
                side_reg[k] <= side_next[k];
            end
        end
        if (adv[NS-1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/stvk_strain.sv =====
// Green strain and stress factor M = alpha*tr(S)*I + 2*beta*S from the gradient.
// Six register stages; depends on stvk_pkg.
module stvk_strain #(
    parameter int FRAC_BITS = stvk_pkg::FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  stvk_pkg::lame_t   lame,
    input  logic              in_valid,
    output logic              in_stall,
    input  stvk_pkg::grad_t   in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output stvk_pkg::stress_t out_data
);

    localparam int NS = 6;
    localparam stvk_pkg::prod_t HALF_ONE2 = -(64'sd1 <<< (2 * FRAC_BITS - 1));

    logic [NS-1:0]     vld_reg;
    logic [NS-1:0]     adv;
    stvk_pkg::prod_t   sp_reg [0:5];
    stvk_pkg::q_t      s_reg  [0:2];
    stvk_pkg::q_t      s2_reg [0:2];
    stvk_pkg::q_t      tr_reg;
    stvk_pkg::prod_t   cp_reg [0:3];
    stvk_pkg::q_t      c_reg  [0:3];
    stvk_pkg::grad_t   g_reg  [0:4];
    stvk_pkg::stress_t out_reg;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int s = NS - 2; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NS-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (adv[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // Stage payloads; the gradient rides along to the stress stages.
    always_ff @(posedge clk)
    begin
        // Products of F^T F.
        if (adv[0])
        begin
            sp_reg[0] <= in_data.f[0] * in_data.f[0];
            sp_reg[1] <= in_data.f[2] * in_data.f[2];
            sp_reg[2] <= in_data.f[0] * in_data.f[1];
            sp_reg[3] <= in_data.f[2] * in_data.f[3];
            sp_reg[4] <= in_data.f[1] * in_data.f[1];
            sp_reg[5] <= in_data.f[3] * in_data.f[3];
            g_reg[0]  <= in_data;
        end
        // S = (F^T F - I) / 2, rounded.
        if (adv[1])
        begin
            s_reg[0] <= stvk_pkg::sat32(stvk_pkg::rnd_shift(
                stvk_pkg::half_sum(sp_reg[0], sp_reg[1], 1'b0, 1'b0, HALF_ONE2), FRAC_BITS));
            s_reg[1] <= stvk_pkg::sat32(stvk_pkg::rnd_shift(
                stvk_pkg::half_sum(sp_reg[2], sp_reg[3], 1'b0, 1'b0, '0), FRAC_BITS));
            s_reg[2] <= stvk_pkg::sat32(stvk_pkg::rnd_shift(
                stvk_pkg::half_sum(sp_reg[4], sp_reg[5], 1'b0, 1'b0, HALF_ONE2), FRAC_BITS));
            g_reg[1] <= g_reg[0];
        end
        // Trace.
        if (adv[2])
        begin
            tr_reg <= stvk_pkg::sat32(64'(s_reg[0]) + 64'(s_reg[2]));
            for (int i = 0; i < 3; i++)
            begin
                s2_reg[i] <= s_reg[i];
            end
            g_reg[2] <= g_reg[1];
        end
        // Coefficient products.
        if (adv[3])
        begin
            cp_reg[0] <= $signed({1'b0, lame.alpha}) * tr_reg;
            cp_reg[1] <= $signed({1'b0, lame.beta}) * s2_reg[0];
            cp_reg[2] <= $signed({1'b0, lame.beta}) * s2_reg[1];
            cp_reg[3] <= $signed({1'b0, lame.beta}) * s2_reg[2];
            g_reg[3]  <= g_reg[2];
        end
        // Round coefficient products back to Q format.
        if (adv[4])
        begin
            for (int i = 0; i < 4; i++)
            begin
                c_reg[i] <= stvk_pkg::sat32(stvk_pkg::rnd_shift(cp_reg[i], FRAC_BITS));
            end
            g_reg[4] <= g_reg[3];
        end
        // M entries.
        if (adv[5])
        begin
            out_reg.f    <= g_reg[4].f;
            out_reg.side <= g_reg[4].side;
            out_reg.m00  <= stvk_pkg::sat32(64'(c_reg[0]) + 2 * 64'(c_reg[1]));
            out_reg.m01  <= stvk_pkg::sat32(2 * 64'(c_reg[2]));
            out_reg.m11  <= stvk_pkg::sat32(64'(c_reg[0]) + 2 * 64'(c_reg[3]));
        end
    end

endmodule

// ===== rtl/stvk_force.sv =====
// Stress P = F * M and nodal forces from P and the rest edges, with final clipping.
// Five register stages, the last one is the result register; depends on stvk_pkg.
module stvk_force #(
    parameter int FRAC_BITS = stvk_pkg::FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  stvk_pkg::stress_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output stvk_pkg::tri_out_t out_data
);

    localparam int NS = 5;

    logic [NS-1:0]        vld_reg;
    logic [NS-1:0]        adv;
    stvk_pkg::prod_t      pp_reg  [0:7];
    stvk_pkg::q_t         p_reg   [0:3];
    stvk_pkg::prod_t      fp_reg  [0:7];
    stvk_pkg::prod_t      raw_reg [0:3];
    stvk_pkg::edge_side_t side_reg[0:3];
    stvk_pkg::tri_out_t   out_reg;
    stvk_pkg::tri_out_t   out_next;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int s = NS - 2; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NS-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (adv[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // Orientation, force on vertex a, and clipping to the output range.
    always_comb
    begin
        stvk_pkg::prod_t bx;
        stvk_pkg::prod_t by;
        stvk_pkg::prod_t cx;
        stvk_pkg::prod_t cy;
        stvk_pkg::prod_t ax;
        stvk_pkg::prod_t ay;
        logic            hit;
        bx = side_reg[3].det_pos ? -raw_reg[0] : raw_reg[0];
        by = side_reg[3].det_pos ? -raw_reg[1] : raw_reg[1];
        cx = side_reg[3].det_pos ? -raw_reg[2] : raw_reg[2];
        cy = side_reg[3].det_pos ? -raw_reg[3] : raw_reg[3];
        ax = -(bx + cx);
        ay = -(by + cy);
        out_next.force_ax = stvk_pkg::sat32(ax);
        out_next.force_ay = stvk_pkg::sat32(ay);
        out_next.force_bx = stvk_pkg::sat32(bx);
        out_next.force_by = stvk_pkg::sat32(by);
        out_next.force_cx = stvk_pkg::sat32(cx);
        out_next.force_cy = stvk_pkg::sat32(cy);
        hit = (64'(out_next.force_ax) != ax) || (64'(out_next.force_ay) != ay)
           || (64'(out_next.force_bx) != bx) || (64'(out_next.force_by) != by)
           || (64'(out_next.force_cx) != cx) || (64'(out_next.force_cy) != cy);
        out_next.saturated  = hit;
        out_next.degenerate = 1'b0;
        // A degenerate rest triangle gives zero forces and only the flag.
        if (side_reg[3].degen)
        begin
            out_next = '0;
            out_next.degenerate = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        // Products of F and M.
        if (adv[0])
        begin
            pp_reg[0] <= in_data.f[0] * in_data.m00;
            pp_reg[1] <= in_data.f[1] * in_data.m01;
            pp_reg[2] <= in_data.f[0] * in_data.m01;
            pp_reg[3] <= in_data.f[1] * in_data.m11;
            pp_reg[4] <= in_data.f[2] * in_data.m00;
            pp_reg[5] <= in_data.f[3] * in_data.m01;
            pp_reg[6] <= in_data.f[2] * in_data.m01;
            pp_reg[7] <= in_data.f[3] * in_data.m11;
            side_reg[0] <= in_data.side;
        end
        // P entries p00, p01, p10, p11.
        if (adv[1])
        begin
            for (int j = 0; j < 4; j++)
            begin
                p_reg[j] <= stvk_pkg::sat32(stvk_pkg::rnd_shift(
                    stvk_pkg::half_sum(pp_reg[2*j], pp_reg[2*j+1], 1'b0, 1'b0, '0),
                    FRAC_BITS - 1));
            end
            side_reg[1] <= side_reg[0];
        end
        // Products of P and the adjugate of the rest edges.
        if (adv[2])
        begin
            fp_reg[0] <= p_reg[0] * side_reg[1].e2y;
            fp_reg[1] <= p_reg[1] * side_reg[1].e2x;
            fp_reg[2] <= p_reg[2] * side_reg[1].e2y;
            fp_reg[3] <= p_reg[3] * side_reg[1].e2x;
            fp_reg[4] <= p_reg[0] * side_reg[1].e1y;
            fp_reg[5] <= p_reg[1] * side_reg[1].e1x;
            fp_reg[6] <= p_reg[2] * side_reg[1].e1y;
            fp_reg[7] <= p_reg[3] * side_reg[1].e1x;
            side_reg[2] <= side_reg[1];
        end
        // Unclipped forces on b and c.
        if (adv[3])
        begin
            raw_reg[0] <= stvk_pkg::rnd_shift(
                stvk_pkg::half_sum(fp_reg[0], fp_reg[1], 1'b0, 1'b1, '0), FRAC_BITS);
            raw_reg[1] <= stvk_pkg::rnd_shift(
                stvk_pkg::half_sum(fp_reg[2], fp_reg[3], 1'b0, 1'b1, '0), FRAC_BITS);
            raw_reg[2] <= stvk_pkg::rnd_shift(
                stvk_pkg::half_sum(fp_reg[4], fp_reg[5], 1'b1, 1'b0, '0), FRAC_BITS);
            raw_reg[3] <= stvk_pkg::rnd_shift(
                stvk_pkg::half_sum(fp_reg[6], fp_reg[7], 1'b1, 1'b0, '0), FRAC_BITS);
            side_reg[3] <= side_reg[2];
        end
        if (adv[4])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/stvk_triangle_force_top.sv =====
// Depth: 47 register stages.
// Throughput: one triangle per cycle while the output is not stalled; the 33-stage quotient divider sets the depth.
// Each stage holds its data while the next is full and cannot move on, so bubbles close up under stall.
// Reset clears all valid bits and sets both Lame coefficients to 1.0.
// Top level: configuration registers and the four pipeline sections; uses stvk_pkg.
module stvk_triangle_force_top #(
    parameter int FRAC_BITS = stvk_pkg::FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  stvk_pkg::tri_in_t                 req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output stvk_pkg::tri_out_t                rsp_data,
    input  logic                              cfg_we,
    input  logic [stvk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stvk_pkg::W-1:0]            cfg_wdata
);

    logic [stvk_pkg::W-1:0] lame_alpha_reg;
    logic [stvk_pkg::W-1:0] lame_beta_reg;
    stvk_pkg::lame_t        lame;

    logic              geom_valid;
    logic              geom_stall;
    stvk_pkg::geom_t   geom_data;
    logic              grad_valid;
    logic              grad_stall;
    stvk_pkg::grad_t   grad_data;
    logic              stress_valid;
    logic              stress_stall;
    stvk_pkg::stress_t stress_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lame_alpha_reg <= stvk_pkg::LAME_RESET;
            lame_beta_reg  <= stvk_pkg::LAME_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stvk_pkg::CFG_ALPHA: lame_alpha_reg <= cfg_wdata;
                stvk_pkg::CFG_BETA:  lame_beta_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign lame.alpha = lame_alpha_reg;
    assign lame.beta  = lame_beta_reg;

    stvk_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_stall  (req_stall),
        .in_data   (req_data),
        .out_valid (geom_valid),
        .out_stall (geom_stall),
        .out_data  (geom_data)
    );

    stvk_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_stall  (geom_stall),
        .in_data   (geom_data),
        .out_valid (grad_valid),
        .out_stall (grad_stall),
        .out_data  (grad_data)
    );

    stvk_strain #(.FRAC_BITS(FRAC_BITS)) u_strain (
        .clk       (clk),
        .rst_n     (rst_n),
        .lame      (lame),
        .in_valid  (grad_valid),
        .in_stall  (grad_stall),
        .in_data   (grad_data),
        .out_valid (stress_valid),
        .out_stall (stress_stall),
        .out_data  (stress_data)
    );

    stvk_force #(.FRAC_BITS(FRAC_BITS)) u_force (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stress_valid),
        .in_stall  (stress_stall),
        .in_data   (stress_data),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_data  (rsp_data)
    );

`ifndef SYNTHESIS
    // A degenerate triangle reports zero forces and no clipping.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.degenerate |->
            !rsp_data.saturated && rsp_data.force_ax == '0 && rsp_data.force_by == '0
            && rsp_data.force_cy == '0)
        else $error("degenerate result carries nonzero data");

    // Without clipping, the forces sum to zero in each axis.
    a_balance_x: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.saturated |->
            stvk_pkg::q_t'(rsp_data.force_ax + rsp_data.force_bx + rsp_data.force_cx) == '0)
        else $error("x forces do not balance");

    a_balance_y: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.saturated |->
            stvk_pkg::q_t'(rsp_data.force_ay + rsp_data.force_by + rsp_data.force_cy) == '0)
        else $error("y forces do not balance");

    // A coefficient write lands in the next cycle.
    a_cfg_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == stvk_pkg::CFG_ALPHA |=> lame_alpha_reg == $past(cfg_wdata))
        else $error("alpha write lost");
`endif

endmodule
